// ===== rtl/core/mmrs_pkg.sv =====
// mmrs_pkg: item types, binding layout and shared constants of the macro router
`timescale 1ns / 1ps

package mmrs_pkg;

	// one input item: a midi event or a smoothing tick
	typedef struct packed {
		logic        kind;
		logic [1:0]  event_type;
		logic [4:0]  midi_channel;
		logic [6:0]  number;
		logic [6:0]  value;
		logic [12:0] num_samples;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [1:0]  macro_index;
		logic [16:0] macro_level;
		logic        target_only;
		logic        last;
	} out_item_t;

	// binding register layout, msb first: valid, is_note, channel, number
	typedef struct packed {
		logic       valid;
		logic       is_note;
		logic [4:0] channel;
		logic [6:0] number;
	} binding_t;

	// outcome of matching an event against the bindings
	typedef struct packed {
		logic        hit;
		logic [1:0]  idx;
		logic [16:0] level;
	} match_t;

	// item kinds
	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// event types
	localparam logic [1:0] EV_CC   = 2'd0;
	localparam logic [1:0] EV_NOTE = 2'd1;

	// register indexes
	localparam logic [2:0] REG_SMOOTH = 3'd0;
	localparam logic [2:0] REG_COEF   = 3'd1;
	localparam logic [2:0] REG_BIND0  = 3'd2;

	// q16 levels
	localparam logic [16:0] Q16_ONE     = 17'd65536;
	localparam logic [16:0] LEVEL_RESET = 17'd32768;
	localparam logic [16:0] COEF_RESET  = 17'd152;
	localparam logic [16:0] SNAP_LSB    = 17'd7;
	localparam logic [33:0] ROUND_HALF  = 34'd32768;

	// 65536 = 127 * 516 + 4
	localparam logic [16:0] NORM_SCALE = 17'd516;
	localparam logic [8:0]  NORM_DIV   = 9'd127;

endpackage

// ===== rtl/core/mmrs_match.sv =====
// mmrs_match: binding match with lowest-index priority and q16 normalisation of the value
`timescale 1ns / 1ps

module mmrs_match #(
	parameter int MACRO_COUNT = 4
) (
	input  mmrs_pkg::binding_t bindings [MACRO_COUNT],
	input  mmrs_pkg::in_item_t item,
	output mmrs_pkg::match_t   result
);

	logic [8:0]  val_x4;
	logic [2:0]  frac;
	logic        usable;

	function automatic logic [8:0] NORM_DIV_X(input int k);
		return 9'(k * int'(mmrs_pkg::NORM_DIV));
	endfunction

	// floor(v * 65536 / 127) = 516 * v + floor(4 * v / 127)
	always_comb begin
		val_x4 = {item.value, 2'b00};
		frac = 3'd0;
		if (val_x4 >= NORM_DIV_X(1)) frac = 3'd1;
		if (val_x4 >= NORM_DIV_X(2)) frac = 3'd2;
		if (val_x4 >= NORM_DIV_X(3)) frac = 3'd3;
		if (val_x4 >= NORM_DIV_X(4)) frac = 3'd4;
	end

	// controller change, or note-on with nonzero velocity
	assign usable = (item.event_type == mmrs_pkg::EV_CC) ||
		((item.event_type == mmrs_pkg::EV_NOTE) && (item.value != 7'd0));

	// scan downwards so the lowest matching macro is kept
	always_comb begin
		result = '0;
		result.level = 17'(item.value) * mmrs_pkg::NORM_SCALE + 17'(frac);
		if (usable) begin
			for (int i = MACRO_COUNT - 1; i >= 0; i--) begin
				if (bindings[i].valid &&
					({1'b0, bindings[i].is_note} == item.event_type) &&
					(bindings[i].number == item.number) &&
					((bindings[i].channel == item.midi_channel) ||
					 (bindings[i].channel == 5'd0))) begin
					result.hit = 1'b1;
					result.idx = 2'(i);
				end
			end
		end
	end

endmodule

// ===== rtl/core/midi_macro_router_smoother.sv =====
// midi_macro_router_smoother: top level, register file, sequencer and shared multiplier
`timescale 1ns / 1ps

// Routes midi controller and note-on events to up to four macros and smooths
// macro levels on block ticks.
// Channels: req_item is taken when req_valid is high and req_stall low;
// rsp_item is handed over when rsp_valid is high and rsp_stall low. Registers
// are written on the cfg channel (cfg_ready is always high); the user is to
// write them only while idle, which the block itself does not enforce.
// An event that matches a binding passes the dispatch and emit states and
// presents one item at the output register; an unmatched or ignored event,
// or a tick with smoothing off, gives none. A tick with smoothing on walks
// the macros in rising order through one shared 17x17 multiplier: first the
// coefficient num_samples * coef_per_sample, then one product per macro that
// still moves. A macro that moves passes the diff, step and emit states and
// gives one item; a macro that snaps passes only the diff state.
// One item is worked on at a time; req_stall is high while busy.
// A held result stalls the sequencer until rsp_stall drops; nothing is lost.
// Reset sets every level and target to 0.5, smoothing on, coefficient 152
// and all bindings invalid.

module midi_macro_router_smoother #(
	parameter int MACRO_COUNT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mmrs_pkg::in_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mmrs_pkg::out_item_t rsp_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data
);

	localparam int IW = (MACRO_COUNT > 1) ? $clog2(MACRO_COUNT) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_CSAT = 3'd2;
	localparam logic [2:0] ST_DIFF = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]          state_q;
	mmrs_pkg::in_item_t  item_q;
	logic                smoothing_q;
	logic [16:0]         coef_q;
	mmrs_pkg::binding_t  binding_q [MACRO_COUNT];
	logic [16:0]         tgt_q [MACRO_COUNT];
	logic [16:0]         sm_q [MACRO_COUNT];
	logic [IW-1:0]       idx_q;
	logic [MACRO_COUNT-1:0] mask_q;
	logic [16:0]         c_q;
	logic [33:0]         prod_q;
	logic                neg_q;
	mmrs_pkg::out_item_t res_q;
	mmrs_pkg::out_item_t rsp_q;
	logic                rsp_valid_q;

	mmrs_pkg::match_t    hit;
	logic                cfg_write;
	logic [16:0]         mul_a;
	logic [16:0]         mul_b;
	logic [33:0]         mul_p;
	logic [16:0]         cur_mag;
	logic [MACRO_COUNT-1:0] move;
	logic                later;
	logic [17:0]         step_mag;
	logic [18:0]         step_sum;
	logic [16:0]         new_level;
	logic                out_free;
	logic                idx_end;

	function automatic logic [16:0] abs_diff(input logic [16:0] a, input logic [16:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign idx_end   = (idx_q == IW'(MACRO_COUNT - 1));

	// event matcher
	mmrs_match #(
		.MACRO_COUNT (MACRO_COUNT)
	) u_match (
		.bindings (binding_q),
		.item     (item_q),
		.result   (hit)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_q <= 1'b1;
			coef_q <= mmrs_pkg::COEF_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				mmrs_pkg::REG_SMOOTH: smoothing_q <= cfg_data[0];
				mmrs_pkg::REG_COEF:   coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bindings take the low 14 bits of the write data
	for (genvar g = 0; g < MACRO_COUNT; g++) begin : g_bind
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				binding_q[g] <= '0;
			end else if (cfg_write && (cfg_index == 3'(int'(mmrs_pkg::REG_BIND0) + g))) begin
				binding_q[g] <= mmrs_pkg::binding_t'(cfg_data[13:0]);
			end
		end
	end

	// per macro: does it still move by more than the snap window
	always_comb begin
		for (int i = 0; i < MACRO_COUNT; i++) begin
			move[i] = abs_diff(tgt_q[i], sm_q[i]) > mmrs_pkg::SNAP_LSB;
		end
	end

	// is another macro after the current one going to give an item
	always_comb begin
		later = 1'b0;
		for (int i = 0; i < MACRO_COUNT; i++) begin
			if (IW'(i) > idx_q) later = later | mask_q[i];
		end
	end

	assign cur_mag = abs_diff(tgt_q[idx_q], sm_q[idx_q]);

	// shared multiplier: coefficient first, then one step per macro
	always_comb begin
		if (state_q == ST_DISP) begin
			mul_a = {4'b0000, item_q.num_samples};
			mul_b = coef_q;
		end else begin
			mul_a = cur_mag;
			mul_b = c_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	// rounded step and new smoothed level, clamped to 0..1.0
	always_comb begin
		step_mag = 18'((prod_q + mmrs_pkg::ROUND_HALF) >> 16);
		if (neg_q) begin
			step_sum = {2'b00, sm_q[idx_q]} - {1'b0, step_mag};
		end else begin
			step_sum = {2'b00, sm_q[idx_q]} + {1'b0, step_mag};
		end
		if (step_sum[18]) begin
			new_level = 17'd0;
		end else if (step_sum[17:0] > {1'b0, mmrs_pkg::Q16_ONE}) begin
			new_level = mmrs_pkg::Q16_ONE;
		end else begin
			new_level = step_sum[16:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_q <= req_item;
		end
		if ((state_q == ST_DISP) || (state_q == ST_DIFF)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_DISP) begin
			mask_q <= move;
			res_q.macro_index <= hit.idx;
			res_q.macro_level <= hit.level;
			res_q.target_only <= smoothing_q;
			res_q.last <= 1'b1;
		end
		if (state_q == ST_CSAT) begin
			c_q <= (prod_q > 34'(mmrs_pkg::Q16_ONE)) ? mmrs_pkg::Q16_ONE : prod_q[16:0];
		end
		if (state_q == ST_DIFF) begin
			neg_q <= tgt_q[idx_q] < sm_q[idx_q];
		end
		if (state_q == ST_STEP) begin
			res_q.macro_index <= 2'(idx_q);
			res_q.macro_level <= new_level;
			res_q.target_only <= 1'b0;
			res_q.last <= !later;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			rsp_q <= res_q;
		end
	end

	// targets: set by a matched event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MACRO_COUNT; i++) tgt_q[i] <= mmrs_pkg::LEVEL_RESET;
		end else if ((state_q == ST_DISP) && (item_q.kind == mmrs_pkg::KIND_EVENT) &&
			hit.hit) begin
			tgt_q[hit.idx[IW-1:0]] <= hit.level;
		end
	end

	// smoothed levels: snap or step during a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MACRO_COUNT; i++) sm_q[i] <= mmrs_pkg::LEVEL_RESET;
		end else if ((state_q == ST_DIFF) && !mask_q[idx_q]) begin
			sm_q[idx_q] <= tgt_q[idx_q];
		end else if (state_q == ST_STEP) begin
			sm_q[idx_q] <= new_level;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (req_valid) state_q <= ST_DISP;
				end
				ST_DISP: begin
					if (item_q.kind == mmrs_pkg::KIND_EVENT) begin
						state_q <= hit.hit ? ST_EMIT : ST_IDLE;
					end else begin
						state_q <= smoothing_q ? ST_CSAT : ST_IDLE;
					end
				end
				ST_CSAT: state_q <= ST_DIFF;
				ST_DIFF: begin
					if (mask_q[idx_q]) begin
						state_q <= ST_STEP;
					end else if (idx_end) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_STEP: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						if ((item_q.kind == mmrs_pkg::KIND_EVENT) || idx_end) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_DIFF;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/macro_level_checker.sv =====
// macro_level_checker: predicts macro levels and targets and checks every result item
`timescale 1ns / 1ps

module macro_level_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  mmrs_pkg::in_item_t  req_item,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  mmrs_pkg::out_item_t rsp_item,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	output int                  fails,
	output int                  outstanding
);

	localparam int NMACRO = 4;
	localparam int MAX_REPORTS = 10;

	// register copies and macro state
	logic                smooth_on;
	logic [16:0]         coef;
	mmrs_pkg::binding_t  binds [NMACRO];
	logic [16:0]         target [NMACRO];
	logic [16:0]         smoothed [NMACRO];

	// results still owed by the block, oldest first
	mmrs_pkg::out_item_t expected_levels [$];

	// register write as seen on the config channel
	function automatic void apply_write(input logic [2:0] idx, input logic [16:0] data);
		int slot;
		slot = int'(idx) - int'(mmrs_pkg::REG_BIND0);
		if (idx == mmrs_pkg::REG_SMOOTH) begin
			smooth_on = data[0];
		end else if (idx == mmrs_pkg::REG_COEF) begin
			coef = data;
		end else if (slot >= 0 && slot < NMACRO) begin
			binds[slot] = mmrs_pkg::binding_t'(data[13:0]);
		end
	endfunction

	// works out the result items of one accepted item and updates the macro state
	function automatic void predict_levels(input mmrs_pkg::in_item_t it);
		mmrs_pkg::out_item_t batch [NMACRO];
		int        n;
		int        hit;
		longint    c;
		longint    delta;
		longint    mag;
		longint    stepm;
		longint    lvl;
		logic [16:0] norm;
		n = 0;
		hit = -1;
		if (it.kind == mmrs_pkg::KIND_EVENT) begin
			// other messages and note-on with zero velocity are dropped
			if (it.event_type != mmrs_pkg::EV_CC && it.event_type != mmrs_pkg::EV_NOTE) return;
			if (it.event_type == mmrs_pkg::EV_NOTE && it.value == 7'd0) return;
			// lowest matching macro wins, channel 0 in a binding means any channel
			for (int i = 0; i < NMACRO; i++) begin
				if (hit < 0 && binds[i].valid
						&& binds[i].is_note == (it.event_type == mmrs_pkg::EV_NOTE)
						&& binds[i].number == it.number
						&& (binds[i].channel == it.midi_channel || binds[i].channel == 5'd0))
					hit = i;
			end
			if (hit < 0) return;
			norm = 17'((longint'(it.value) * longint'(mmrs_pkg::Q16_ONE))
				/ longint'(mmrs_pkg::NORM_DIV));
			target[hit] = norm;
			batch[0].macro_index = 2'(hit);
			batch[0].macro_level = norm;
			batch[0].target_only = smooth_on;
			batch[0].last = 1'b0;
			n = 1;
		end else if (smooth_on) begin
			// one-pole step per macro, snap when close enough
			c = longint'(it.num_samples) * longint'(coef);
			if (c > longint'(mmrs_pkg::Q16_ONE)) c = longint'(mmrs_pkg::Q16_ONE);
			for (int i = 0; i < NMACRO; i++) begin
				delta = longint'(target[i]) - longint'(smoothed[i]);
				mag = (delta < 0) ? -delta : delta;
				if (mag > longint'(mmrs_pkg::SNAP_LSB)) begin
					stepm = (mag * c + longint'(mmrs_pkg::ROUND_HALF)) >>> 16;
					lvl = (delta < 0) ? longint'(smoothed[i]) - stepm
						: longint'(smoothed[i]) + stepm;
					if (lvl < 0) lvl = 0;
					if (lvl > longint'(mmrs_pkg::Q16_ONE)) lvl = longint'(mmrs_pkg::Q16_ONE);
					smoothed[i] = 17'(lvl);
					batch[n].macro_index = 2'(i);
					batch[n].macro_level = 17'(lvl);
					batch[n].target_only = 1'b0;
					batch[n].last = 1'b0;
					n++;
				end else begin
					smoothed[i] = target[i];
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			if (k == n - 1) batch[k].last = 1'b1;
			expected_levels.push_back(batch[k]);
		end
	endfunction

	// counts a failure, prints only the first few
	function automatic void log_fault(input string why, input mmrs_pkg::out_item_t want,
			input mmrs_pkg::out_item_t got);
		fails++;
		if (fails <= MAX_REPORTS)
			$display("%0t %s: expected idx %0d level %0d tonly %b last %b, %s %0d %0d %b %b",
				$time, why, want.macro_index, want.macro_level, want.target_only, want.last,
				"got idx level tonly last", got.macro_index, got.macro_level,
				got.target_only, got.last);
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_on = 1'b1;
			coef = mmrs_pkg::COEF_RESET;
			for (int i = 0; i < NMACRO; i++) begin
				binds[i] = '0;
				target[i] = mmrs_pkg::LEVEL_RESET;
				smoothed[i] = mmrs_pkg::LEVEL_RESET;
			end
			expected_levels.delete();
			fails = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
			if (req_valid && !req_stall) predict_levels(req_item);
			if (rsp_valid && !rsp_stall) begin
				if (expected_levels.size() == 0) begin
					log_fault("unexpected item", '0, rsp_item);
				end else begin
					if (rsp_item.macro_index !== expected_levels[0].macro_index
							|| rsp_item.macro_level !== expected_levels[0].macro_level
							|| rsp_item.target_only !== expected_levels[0].target_only
							|| rsp_item.last !== expected_levels[0].last)
						log_fault("mismatch", expected_levels[0], rsp_item);
					void'(expected_levels.pop_front());
				end
			end
			outstanding = expected_levels.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus, idling and verdict for the midi macro router
`timescale 1ns / 1ps

module tb;

	// register indexes past the end of the list, which the block ignores
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// event types that carry no controller or note
	localparam logic [1:0] EV_OTHER    = 2'd2;
	localparam logic [1:0] EV_RESERVED = 2'd3;

	// idle time after the last owed result, longer than the longest tick walk
	localparam int SETTLE_CYCLES = 24;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	mmrs_pkg::in_item_t  req_item = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	mmrs_pkg::out_item_t rsp_item;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [2:0]          cfg_index = '0;
	logic [16:0]         cfg_data = '0;

	int fails;
	int outstanding;
	int req_gap_pct = 19;
	int rsp_gap_pct = 84;

	mmrs_pkg::binding_t bind_set [4];

	always #5 clk = ~clk;

	midi_macro_router_smoother i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	macro_level_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_item    (req_item),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_item    (rsp_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.outstanding (outstanding)
	);

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
	end

	// overall time limit
	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic mmrs_pkg::in_item_t make_event(input logic [1:0] et,
			input logic [4:0] ch, input logic [6:0] num, input logic [6:0] val);
		mmrs_pkg::in_item_t it;
		it.kind = mmrs_pkg::KIND_EVENT;
		it.event_type = et;
		it.midi_channel = ch;
		it.number = num;
		it.value = val;
		it.num_samples = 13'($urandom);
		return it;
	endfunction

	function automatic mmrs_pkg::in_item_t make_tick(input logic [12:0] ns);
		mmrs_pkg::in_item_t it;
		it.kind = mmrs_pkg::KIND_TICK;
		it.event_type = 2'($urandom);
		it.midi_channel = 5'($urandom);
		it.number = 7'($urandom);
		it.value = 7'($urandom);
		it.num_samples = ns;
		return it;
	endfunction

	// one item on the request channel, with random idle cycles before it
	task automatic send_item(input mmrs_pkg::in_item_t it);
		while ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_item <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// let every owed result come out and the block fall idle
	task automatic drain;
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// writes every register, plus the two unused indexes
	task automatic configure(input logic smooth, input logic [16:0] coef);
		write_reg(mmrs_pkg::REG_SMOOTH, {16'($urandom), smooth});
		write_reg(mmrs_pkg::REG_COEF, coef);
		for (int i = 0; i < 4; i++)
			write_reg(3'(mmrs_pkg::REG_BIND0 + i), {3'($urandom), bind_set[i]});
		write_reg(REG_SPARE_LO, 17'($urandom));
		write_reg(REG_SPARE_HI, 17'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random bindings, some copying the one below them with any channel
	task automatic shuffle_bindings;
		for (int i = 0; i < 4; i++) begin
			if (i > 0 && $urandom_range(3) == 0) begin
				bind_set[i] = bind_set[i - 1];
				bind_set[i].channel = '0;
			end else begin
				bind_set[i] = mmrs_pkg::binding_t'(14'($urandom));
				if ($urandom_range(7) != 0) bind_set[i].valid = 1'b1;
				if ($urandom_range(1) == 0) bind_set[i].channel = '0;
			end
		end
	endtask

	// mostly events aimed at a binding and ticks, the rest noise
	task automatic random_phase(input int count);
		int                 useful;
		int                 r;
		mmrs_pkg::binding_t b;
		mmrs_pkg::in_item_t it;
		useful = 0;
		while (useful < count) begin
			r = $urandom_range(99);
			if (r < 55) begin
				b = bind_set[$urandom_range(3)];
				it = make_event(b.is_note ? mmrs_pkg::EV_NOTE : mmrs_pkg::EV_CC,
					(b.channel == 5'd0) ? 5'($urandom) : b.channel, b.number, 7'($urandom));
				if (b.is_note && $urandom_range(9) == 0) it.value = '0;
				useful++;
			end else if (r < 85) begin
				it = make_tick(($urandom_range(7) == 0) ? 13'($urandom)
					: 13'($urandom_range(24)));
				useful++;
			end else begin
				it = make_event(2'($urandom), 5'($urandom), 7'($urandom), 7'($urandom));
			end
			send_item(it);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: nothing bound, every macro already at its target
		send_item(make_tick(13'd100));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd1, 7'd0, 7'd127));
		drain();

		// any-channel controller, exact-channel note, shadowed binding
		bind_set[0] = '{1'b1, 1'b0, 5'd0, 7'd0};
		bind_set[1] = '{1'b1, 1'b1, 5'd16, 7'd127};
		bind_set[2] = '{1'b1, 1'b0, 5'd5, 7'd64};
		bind_set[3] = '{1'b1, 1'b0, 5'd0, 7'd64};
		configure(1'b1, 17'd152);
		send_item(make_event(mmrs_pkg::EV_CC, 5'd1, 7'd0, 7'd127));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd16, 7'd0, 7'd0));
		send_item(make_event(mmrs_pkg::EV_NOTE, 5'd16, 7'd127, 7'd127));
		send_item(make_event(mmrs_pkg::EV_NOTE, 5'd16, 7'd127, 7'd0));
		send_item(make_event(mmrs_pkg::EV_NOTE, 5'd15, 7'd127, 7'd64));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd16, 7'd127, 7'd1));
		send_item(make_event(EV_OTHER, 5'd16, 7'd0, 7'd5));
		send_item(make_event(EV_RESERVED, 5'd1, 7'd0, 7'd5));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd5, 7'd64, 7'd100));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd6, 7'd64, 7'd50));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd31, 7'd64, 7'd1));
		send_item(make_tick(13'd0));
		send_item(make_tick(13'd1));
		send_item(make_tick(13'd8191));
		send_item(make_tick(13'd4096));
		drain();

		// smoothing off, largest coefficient, out-of-range channel, invalid binding
		bind_set[0] = '{1'b1, 1'b1, 5'd31, 7'd127};
		bind_set[1] = '{1'b1, 1'b0, 5'd0, 7'd127};
		bind_set[2] = '{1'b0, 1'b0, 5'd0, 7'd0};
		bind_set[3] = '{1'b1, 1'b0, 5'd0, 7'd0};
		configure(1'b0, 17'h10000);
		send_item(make_event(mmrs_pkg::EV_NOTE, 5'd31, 7'd127, 7'd1));
		send_item(make_event(mmrs_pkg::EV_NOTE, 5'd30, 7'd127, 7'd1));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd3, 7'd0, 7'd127));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd0, 7'd127, 7'd64));
		send_item(make_tick(13'd8191));
		drain();

		// zero coefficient: levels far from target are reported unmoved
		configure(1'b1, 17'd0);
		send_item(make_tick(13'd8191));
		send_item(make_event(mmrs_pkg::EV_CC, 5'd9, 7'd127, 7'd3));
		drain();

		// random items, sender idles little and receiver a lot
		shuffle_bindings();
		configure(1'b1, 17'($urandom_range(1, 600)));
		random_phase(28);
		drain();

		// sender idles a lot, receiver little
		req_gap_pct = 84;
		rsp_gap_pct = 19;
		shuffle_bindings();
		configure(1'b1, 17'h10000);
		random_phase(28);
		drain();

		// no idling on either side
		req_gap_pct = 0;
		rsp_gap_pct = 0;
		shuffle_bindings();
		configure(1'b0, 17'd152);
		random_phase(14);
		drain();
		shuffle_bindings();
		configure(1'b1, 17'd152);
		random_phase(22);
		drain();

		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
